@@ rtl/packbits_row_decoder_core_defines.svh @@
// ----------------------------------------------------------------------------
// PackBits row decoder assertion macros
// Shared assertion forms for the PackBits row decoder checkers.
// ----------------------------------------------------------------------------
`ifndef PACKBITS_ROW_DECODER_CORE_DEFINES_SVH
`define PACKBITS_ROW_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PBRD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pbrd_pkg.sv @@
// ----------------------------------------------------------------------------
// PackBits row decoder package
// Shared types, register indexes and defaults of the PackBits row decoder.
// ----------------------------------------------------------------------------
package pbrd_pkg;

  localparam int PBRD_MAX_ROW_BYTES = 4096;

  localparam int ROW_BYTES_W = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;

  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 13'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE  = 1'b1;

  // Decoder phase, one-hot.
  typedef enum logic [3:0] {
    PH_CTRL = 4'b0001,
    PH_LIT  = 4'b0010,
    PH_REP  = 4'b0100,
    PH_SKIP = 4'b1000
  } phase_t;

  // One decoded result transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] repeat_count;
    logic       row_end;
    logic       overrun;
  } result_t;

endpackage

@@ rtl/pbrd_step.sv @@
// ----------------------------------------------------------------------------
// PackBits row decoder step
// Next-state and result logic for one accepted byte.
// ----------------------------------------------------------------------------
module pbrd_step
  import pbrd_pkg::*;
#(
  parameter int MAX_ROW_BYTES = PBRD_MAX_ROW_BYTES,
  parameter int ROW_W         = $clog2(MAX_ROW_BYTES + 1)
) (
  input  logic [7:0]             in_byte,
  input  logic                   raw_mode,
  input  logic [ROW_BYTES_W-1:0] row_bytes,
  input  phase_t                 phase,
  input  logic [7:0]             run_left,
  input  logic [ROW_W-1:0]       row_left,
  output phase_t                 phase_nxt,
  output logic [7:0]             run_left_nxt,
  output logic [ROW_W-1:0]       row_left_nxt,
  output logic                   res_valid,
  output result_t                res
);

  localparam int CW = (ROW_W > ROW_BYTES_W) ? ROW_W : ROW_BYTES_W;
  localparam int RW = (ROW_W > 8) ? ROW_W : 8;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ROW_BYTES);

  logic [CW-1:0]    len_ext;
  logic [CW-1:0]    len_sat;
  logic [ROW_W-1:0] row_eff;
  logic [ROW_W-1:0] row_dec;
  logic [7:0]       run_dec;
  logic [RW-1:0]    cnt_w;
  logic [RW-1:0]    row_w;
  logic [RW-1:0]    cnt_clip;
  logic             rep_ovr;

  // Row length as it takes effect at a row start: zero means one, and
  // anything above the maximum saturates.
  always_comb begin
    len_ext = CW'(row_bytes);
    if (len_ext == '0) begin
      len_sat = CW'(1);
    end else if (len_ext > MAX_C) begin
      len_sat = MAX_C;
    end else begin
      len_sat = len_ext;
    end
  end

  assign row_eff = (row_left == '0) ? ROW_W'(len_sat) : row_left;
  assign row_dec = row_eff - ROW_W'(1);
  assign run_dec = (run_left != 8'd0) ? (run_left - 8'd1) : 8'd0;

  // Repeat clipping against what is left of the row.
  assign cnt_w    = RW'(run_left);
  assign row_w    = RW'(row_eff);
  assign rep_ovr  = cnt_w > row_w;
  assign cnt_clip = rep_ovr ? row_w : cnt_w;

  always_comb begin
    phase_nxt        = phase;
    run_left_nxt     = run_left;
    row_left_nxt     = row_left;
    res_valid        = 1'b0;
    res.data_byte    = in_byte;
    res.repeat_count = 8'd1;
    res.row_end      = 1'b0;
    res.overrun      = 1'b0;
    if (raw_mode) begin
      phase_nxt    = PH_CTRL;
      run_left_nxt = 8'd0;
      row_left_nxt = row_dec;
      res_valid    = 1'b1;
      res.row_end  = (row_dec == '0);
    end else begin
      case (phase)
        PH_CTRL: begin
          row_left_nxt = row_eff;
          if (!in_byte[7]) begin
            run_left_nxt = in_byte + 8'd1;
            phase_nxt    = PH_LIT;
          end else if (in_byte != 8'h80) begin
            run_left_nxt = 8'(9'd257 - {1'b0, in_byte});
            phase_nxt    = PH_REP;
          end else begin
            run_left_nxt = 8'd0;
          end
        end
        PH_LIT: begin
          row_left_nxt = row_dec;
          run_left_nxt = run_dec;
          res_valid    = 1'b1;
          res.row_end  = (row_dec == '0);
          res.overrun  = (row_dec == '0) && (run_dec != 8'd0);
          if (run_dec == 8'd0) begin
            phase_nxt = PH_CTRL;
          end else if (row_dec == '0) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_REP: begin
          row_left_nxt     = ROW_W'(row_w - cnt_clip);
          run_left_nxt     = 8'd0;
          phase_nxt        = PH_CTRL;
          res_valid        = 1'b1;
          res.repeat_count = 8'(cnt_clip);
          res.row_end      = (row_w == cnt_clip);
          res.overrun      = rep_ovr;
        end
        PH_SKIP: begin
          run_left_nxt = run_dec;
          if (run_dec == 8'd0) begin
            phase_nxt = PH_CTRL;
          end
        end
        default: begin
          phase_nxt    = PH_CTRL;
          run_left_nxt = 8'd0;
        end
      endcase
    end
  end

endmodule

@@ rtl/packbits_row_decoder_core.sv @@
// ----------------------------------------------------------------------------
// PackBits row decoder core
// Decodes a PackBits byte stream into byte/count results split into rows.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   in_*      input      in_valid/in_stall  in_byte
//   out_*     output     out_valid/out_stall data_byte, repeat_count,
//                                            row_end, overrun
//   cfg_*     input      cfg_we             cfg_index, cfg_wdata
//
// One byte is taken per cycle while in_stall is low; its result, if it has
// one, goes to the output register, or to the skid register while the output
// is stalled. The decode state (phase, run, row counters) advances per byte.
// Reset is synchronous and active low; it clears the decode state and the
// output and skid valid flags and restores the register defaults.
// A stalled output holds its transaction; one more result is caught in a
// skid register, and only while that register is full does in_stall rise.
//
module packbits_row_decoder_core
  import pbrd_pkg::*;
#(
  parameter int MAX_ROW_BYTES = PBRD_MAX_ROW_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_data_byte,
  output logic [7:0]             out_repeat_count,
  output logic                   out_row_end,
  output logic                   out_overrun,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int ROW_W = $clog2(MAX_ROW_BYTES + 1);

  // Configuration registers.
  logic [ROW_BYTES_W-1:0] row_bytes_r;
  logic                   raw_mode_r;

  // Decode state.
  phase_t           phase_r;
  phase_t           phase_nxt;
  logic [7:0]       run_left_r;
  logic [7:0]       run_left_nxt;
  logic [ROW_W-1:0] row_left_r;
  logic [ROW_W-1:0] row_left_nxt;

  // Result of the byte being accepted this cycle.
  logic    res_valid;
  result_t res;

  // Output register and skid register.
  logic    out_valid_r;
  result_t out_r;
  logic    skid_valid_r;
  result_t skid_r;

  logic in_fire;
  logic out_take;

  assign in_fire  = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  // Register writes arrive only while the decoder is idle: the user must keep to this; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= ROW_BYTES_RST;
      raw_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_BYTES: row_bytes_r <= cfg_wdata[ROW_BYTES_W-1:0];
        CFG_RAW_MODE:  raw_mode_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  pbrd_step #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .ROW_W         (ROW_W)
  ) u_step (
    .in_byte      (in_byte),
    .raw_mode     (raw_mode_r),
    .row_bytes    (row_bytes_r),
    .phase        (phase_r),
    .run_left     (run_left_r),
    .row_left     (row_left_r),
    .phase_nxt    (phase_nxt),
    .run_left_nxt (run_left_nxt),
    .row_left_nxt (row_left_nxt),
    .res_valid    (res_valid),
    .res          (res)
  );

  // The decode state moves only when a byte is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CTRL;
      run_left_r <= 8'd0;
      row_left_r <= '0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      run_left_r <= run_left_nxt;
      row_left_r <= row_left_nxt;
    end
  end

  // Output side. A waiting skid entry always moves to the output register
  // first; while it waits no byte is accepted, so ordering is kept. A new
  // result goes to the output register when that register is free or is
  // being taken, and to the skid register otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= in_fire && res_valid;
    end else if (in_fire && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (!out_valid_r || out_take) begin
      if (in_fire && res_valid) begin
        out_r <= res;
      end
    end else if (in_fire && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_byte    = out_r.data_byte;
  assign out_repeat_count = out_r.repeat_count;
  assign out_row_end      = out_r.row_end;
  assign out_overrun      = out_r.overrun;

endmodule

@@ rtl/pbrd_checker.sv @@
// ----------------------------------------------------------------------------
// PackBits row decoder checker
// Port-level assertions for the PackBits row decoder, bound to the core.
// ----------------------------------------------------------------------------
`include "packbits_row_decoder_core_defines.svh"

module pbrd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_byte,
  input logic [7:0] out_repeat_count,
  input logic       out_row_end,
  input logic       out_overrun
);

  logic [17:0] out_pl;
  logic        out_held;
  logic        cnt_ok;

  assign out_pl   = {out_data_byte, out_repeat_count, out_row_end, out_overrun};
  assign out_held = out_valid && out_stall;
  assign cnt_ok   = (out_repeat_count != 8'd0) && (out_repeat_count <= 8'd128);

  // A stalled result transaction stays and holds its payload.
  `PBRD_ASSERT_NXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_pl), "held result moved")

  // A clipped run always ends its row.
  `PBRD_ASSERT_IMP(a_ovr_end, clk, rst_n, out_valid && out_overrun, out_row_end, "overrun, no row end")

  // Counts stay within one to 128 after clipping.
  `PBRD_ASSERT_IMP(a_cnt_rng, clk, rst_n, out_valid, cnt_ok, "repeat count out of range")

  // Input back-pressure only arises behind a pending result.
  `PBRD_ASSERT_IMP(a_stall_src, clk, rst_n, in_stall, out_valid, "input stalled with empty output")

endmodule

bind packbits_row_decoder_core pbrd_checker u_pbrd_checker (.*);

@@ verif/tb_packbits_row_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits row decoder core testbench
// Drives byte transactions through the decoder under random idle and stall
// and checks every result field against a cycle-free decode model.
// ----------------------------------------------------------------------------
module tb_packbits_row_decoder_core;
  import pbrd_pkg::*;

  // Cycles to let a byte with no result work its way through the decoder
  // before a register write.
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 145;

  // One row of the directed table: either a stream byte or a register write.
  typedef enum {STEP_BYTE, STEP_ROW_BYTES, STEP_RAW_MODE} step_kind_t;

  typedef struct {
    step_kind_t             kind;
    logic [CFG_DATA_W-1:0]  value;
    bit                     typed;
    result_t                res;
  } plan_step_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic [7:0]            in_byte   = 8'h00;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic [7:0]            out_data_byte;
  logic [7:0]            out_repeat_count;
  logic                  out_row_end;
  logic                  out_overrun;

  // Decode model state, kept at the block's own widths.
  logic [ROW_BYTES_W-1:0] model_row_bytes = ROW_BYTES_RST;
  logic                   model_raw       = 1'b0;
  phase_t                 model_phase     = PH_CTRL;
  logic [7:0]             model_run_left  = '0;
  logic [ROW_BYTES_W-1:0] model_row_left  = '0;

  result_t    predicted_runs[$];
  plan_step_t directed_plan[$];
  int         fail_count  = 0;
  int         cycle_count = 0;
  bit         calm        = 1'b0;

  packbits_row_decoder_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_repeat_count (out_repeat_count),
    .out_row_end      (out_row_end),
    .out_overrun      (out_overrun),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A new row starts only when the previous one has been used up. A length
  // of zero counts as one byte, and anything past the maximum saturates.
  task automatic reload_row_count();
    if (model_row_left == '0) begin
      if (model_row_bytes == '0) begin
        model_row_left = 13'd1;
      end else if (model_row_bytes > PBRD_MAX_ROW_BYTES) begin
        model_row_left = 13'(PBRD_MAX_ROW_BYTES);
      end else begin
        model_row_left = model_row_bytes;
      end
    end
  endtask

  // Advances the decode model by one accepted byte and reports the result
  // transaction it causes, if any.
  task automatic decode_byte(input logic [7:0] b, output bit has, output result_t r);
    int count;
    r   = '0;
    has = 1'b0;
    r.data_byte    = b;
    r.repeat_count = 8'd1;
    if (model_raw) begin
      // Raw bytes drop whatever PackBits run was in progress.
      model_phase    = PH_CTRL;
      model_run_left = '0;
      reload_row_count();
      model_row_left = model_row_left - 1'b1;
      r.row_end = (model_row_left == '0);
      has       = 1'b1;
    end else begin
      case (model_phase)
        PH_CTRL: begin
          reload_row_count();
          if (b < 8'd128) begin
            model_run_left = b + 8'd1;
            model_phase    = PH_LIT;
          end else if (b != 8'd128) begin
            // Signed control n repeats the next byte 1-n times.
            model_run_left = 8'(9'd257 - b);
            model_phase    = PH_REP;
          end else begin
            model_run_left = '0;
          end
        end
        PH_LIT: begin
          reload_row_count();
          model_row_left = model_row_left - 1'b1;
          if (model_run_left != '0) model_run_left = model_run_left - 1'b1;
          r.overrun = (model_row_left == '0) && (model_run_left != '0);
          if (model_run_left == '0) begin
            model_phase = PH_CTRL;
          end else if (model_row_left == '0) begin
            model_phase = PH_SKIP;
          end
          r.row_end = (model_row_left == '0);
          has       = 1'b1;
        end
        PH_REP: begin
          reload_row_count();
          count = model_run_left;
          if (count > model_row_left) begin
            count     = model_row_left;
            r.overrun = 1'b1;
          end
          model_row_left = model_row_left - 13'(count);
          model_run_left = '0;
          model_phase    = PH_CTRL;
          r.repeat_count = 8'(count);
          r.row_end      = (model_row_left == '0);
          has            = 1'b1;
        end
        default: begin
          // Tail of a clipped literal: swallowed without a result.
          if (model_run_left != '0) model_run_left = model_run_left - 1'b1;
          if (model_run_left == '0) model_phase = PH_CTRL;
        end
      endcase
    end
  endtask

  task automatic add_step(input step_kind_t kind, input logic [CFG_DATA_W-1:0] value,
                          input bit typed = 1'b0, input logic [7:0] d = '0,
                          input logic [7:0] c = '0, input logic e = 1'b0,
                          input logic o = 1'b0);
    plan_step_t s;
    s.kind  = kind;
    s.value = value;
    s.typed = typed;
    s.res   = '{data_byte: d, repeat_count: c, row_end: e, overrun: o};
    directed_plan.push_back(s);
  endtask

  // Always waits at least one edge, so a lowered valid is never raised again
  // within the same time step.
  task automatic wait_drained();
    do @(posedge clk); while (predicted_runs.size() != 0);
  endtask

  // Sends one byte transaction, holding it until accepted, then records the
  // result it should cause. A typed expectation replaces the model's.
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t typed_res);
    bit      has;
    result_t r;
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, has, r);
    if (typed) begin
      predicted_runs.push_back(typed_res);
    end else if (has) begin
      predicted_runs.push_back(r);
    end
  endtask

  // Register writes only happen with the decoder idle: no result owed and a
  // settling wait for any byte that produced none.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROW_BYTES) begin
      model_row_bytes = value;
    end else if (idx == CFG_RAW_MODE) begin
      model_raw = value[0];
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Receiver: stalls about one cycle in ten, except during the calm phase.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 10);
  end

  // Every accepted result transaction is matched against the oldest one owed.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_runs.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %0h/%0d/%b/%b",
                 $time, out_data_byte, out_repeat_count, out_row_end, out_overrun);
        fail_count++;
      end else begin
        want = predicted_runs.pop_front();
        check_field("data_byte", want.data_byte, out_data_byte);
        check_field("repeat_count", want.repeat_count, out_repeat_count);
        check_field("row_end", {7'd0, want.row_end}, {7'd0, out_row_end});
        check_field("overrun", {7'd0, want.overrun}, {7'd0, out_overrun});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_packbits_row_decoder_core failed");
      $finish;
    end
  end

  initial begin
    result_t                none;
    plan_step_t             step;
    logic [CFG_DATA_W-1:0]  row;
    bit                     raw;
    bit                     paused;
    int                     sent;
    int                     len;
    int                     pick;
    none = '0;

    // Directed table. Rows start from the reset row length of two bytes.
    add_step(STEP_BYTE, 13'h00);                                  // one-byte literal
    add_step(STEP_BYTE, 13'hFF, 1, 8'hFF, 8'd1, 1'b0, 1'b0);
    add_step(STEP_BYTE, 13'h81);                                  // longest repeat
    add_step(STEP_BYTE, 13'hAA, 1, 8'hAA, 8'd1, 1'b1, 1'b1);      // clipped to the row
    add_step(STEP_BYTE, 13'h80);                                  // no-op, reloads the row
    add_step(STEP_BYTE, 13'h02);                                  // literal that overruns
    add_step(STEP_BYTE, 13'h3C);
    add_step(STEP_BYTE, 13'hC3, 1, 8'hC3, 8'd1, 1'b1, 1'b1);
    add_step(STEP_BYTE, 13'h99);                                  // skipped tail byte
    add_step(STEP_BYTE, 13'hFF);                                  // shortest repeat
    add_step(STEP_BYTE, 13'h00, 1, 8'h00, 8'd2, 1'b1, 1'b0);
    add_step(STEP_ROW_BYTES, 13'd0);                              // zero acts as one
    add_step(STEP_BYTE, 13'hFE);
    add_step(STEP_BYTE, 13'h12, 1, 8'h12, 8'd1, 1'b1, 1'b1);
    add_step(STEP_ROW_BYTES, 13'h1FFF);                           // saturates at the max
    add_step(STEP_BYTE, 13'h81);
    add_step(STEP_BYTE, 13'h77, 1, 8'h77, 8'd128, 1'b0, 1'b0);
    add_step(STEP_BYTE, 13'h05);                                  // literal left open
    add_step(STEP_RAW_MODE, 13'd1);                               // abandons that literal
    add_step(STEP_BYTE, 13'h00, 1, 8'h00, 8'd1, 1'b0, 1'b0);
    add_step(STEP_BYTE, 13'hFF, 1, 8'hFF, 8'd1, 1'b0, 1'b0);
    add_step(STEP_ROW_BYTES, 13'd3);                              // lands at the next row
    add_step(STEP_RAW_MODE, 13'd0);
    add_step(STEP_BYTE, 13'h00);
    add_step(STEP_BYTE, 13'h5A);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      step = directed_plan[i];
      case (step.kind)
        STEP_BYTE:      send_byte(step.value[7:0], step.typed, step.res);
        STEP_ROW_BYTES: write_reg(CFG_ROW_BYTES, step.value);
        default:        write_reg(CFG_RAW_MODE, step.value);
      endcase
    end

    // Random phases. Most rows are short so that row ends and clipping come
    // often; a few phases use the largest lengths and two run in raw mode.
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 2);
      case (p)
        3:       row = 13'd4096;
        6:       row = 13'h1FFF;
        8:       row = 13'd0;
        default: row = 13'($urandom_range(1, 24));
      endcase
      raw = (p == 5) || (p == 9);
      write_reg(CFG_ROW_BYTES, row);
      write_reg(CFG_RAW_MODE, {12'($urandom), raw});
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        // Halfway through, hold off until every owed result has come back.
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          wait_drained();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // Well-formed literal, usually short, now and then up to 128 bytes.
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
          send_byte(8'(len), 1'b0, none);
          repeat (len + 1) send_byte(8'($urandom), 1'b0, none);
          sent += len + 2;
        end else if (pick < 85) begin
          // Well-formed repeat of 2 to 128 bytes.
          send_byte(8'($urandom_range(129, 255)), 1'b0, none);
          send_byte(8'($urandom), 1'b0, none);
          sent += 2;
        end else if (pick < 90) begin
          send_byte(8'h80, 1'b0, none);
          sent++;
        end else begin
          // A stray byte that knocks the framing out of step.
          send_byte(8'($urandom), 1'b0, none);
          sent++;
        end
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && predicted_runs.size() == 0) begin
      $display("tb_packbits_row_decoder_core passed");
    end else begin
      $display("tb_packbits_row_decoder_core failed");
    end
    $finish;
  end

endmodule
